### sv/tte_pkg.sv
// shared constants, register codes and control types of the three tap echo delay
package tte_pkg;

	// defaults for the top level parameters
	localparam int MAX_DELAY_DEF   = 16384;
	localparam int SAMPLE_BITS_DEF = 16;

	// fixed field widths
	localparam int DELAY_BITS      = 15;
	localparam int GAIN_BITS       = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 2;

	// q2.14 gains: fraction bits and rounding bias (half up)
	localparam int FRAC_BITS       = 14;
	localparam int ROUND_BIAS      = 8192;

	// register reset values
	localparam logic [DELAY_BITS-1:0]       DELAY_RST = 15'd1000;
	localparam logic signed [GAIN_BITS-1:0] GAIN1_RST = 16'sd8192;
	localparam logic signed [GAIN_BITS-1:0] GAIN2_RST = 16'sd4096;
	localparam logic signed [GAIN_BITS-1:0] GAIN3_RST = 16'sd2048;

	// register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DELAY_LENGTH = 2'd0,
		REG_FIRST_GAIN   = 2'd1,
		REG_SECOND_GAIN  = 2'd2,
		REG_THIRD_GAIN   = 2'd3
	} tte_reg_t;

	// per cycle controls for the multiply accumulate unit
	typedef struct packed {
		logic load;   // start a new sum from the input sample
		logic mul;    // register gain times tap
		logic add;    // fold the last product into the sum
	} tte_mac_ctl_t;

endpackage

### sv/tte_history_ram.sv
// single port history memory with registered read data
module tte_history_ram #(
	parameter int DEPTH = 4 * tte_pkg::MAX_DELAY_DEF,
	parameter int WIDTH = tte_pkg::SAMPLE_BITS_DEF,
	parameter int AW    = $clog2(4 * tte_pkg::MAX_DELAY_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/tte_mac.sv
// multiply accumulate, rounding and saturation of the echo sum
module tte_mac #(
	parameter int SAMPLE_BITS = tte_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                 clk,
	input  tte_pkg::tte_mac_ctl_t                ctl,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	input  logic signed [tte_pkg::GAIN_BITS-1:0] gain,
	input  logic signed [SAMPLE_BITS-1:0]        tap,
	output logic signed [SAMPLE_BITS-1:0]        result
);

	localparam int FB  = tte_pkg::FRAC_BITS;
	localparam int PW  = SAMPLE_BITS + tte_pkg::GAIN_BITS;
	localparam int ACW = SAMPLE_BITS + 18;
	localparam int QW  = ACW - FB;
	localparam logic signed [QW-1:0] Q_MAX = {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {{(QW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [ACW-1:0] acc_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [ACW-1:0] sum;
	logic signed [QW-1:0]  quo;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= $signed({{(ACW-SAMPLE_BITS-FB){sample[SAMPLE_BITS-1]}}, sample, {FB{1'b0}}})
				+ ACW'(tte_pkg::ROUND_BIAS);
		end else if (ctl.add) begin
			acc_q <= acc_q + ACW'(prod_q);
		end
		if (ctl.mul) begin
			prod_q <= PW'(gain) * PW'(tap);
		end
	end

	// floor by the fraction bits, then clamp to the sample range
	always_comb begin
		sum = acc_q + ACW'(prod_q);
		quo = $signed(sum[ACW-1:FB]);
		if (quo > Q_MAX) begin
			result = Q_MAX[SAMPLE_BITS-1:0];
		end else if (quo < Q_MIN) begin
			result = Q_MIN[SAMPLE_BITS-1:0];
		end else begin
			result = quo[SAMPLE_BITS-1:0];
		end
	end

endmodule

### sv/three_tap_echo_delay.sv
// top level of the three tap feed-forward echo delay
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: sample_in
// m_*      out  m_tvalid/m_tready   m_tdata: sample_out
// cfg_*    in   cfg_we              cfg_index, cfg_data
//
// the pace is set by the single port history memory: three tap reads
// and one sample write per beat; the next beat is taken as the last one finishes
// reset clears pointer, fill count and handshake state and loads the register defaults;
// no clearing pass, the fill count keeps unwritten history slots out of the sum
// a result waits in the output register while the next beat is taken; besides the tap
// and write steps, input stalls only when that register and the finishing stage are both occupied
module three_tap_echo_delay #(
	parameter int MAX_DELAY   = tte_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_BITS = tte_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input beats
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample_in
	// output beats
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,   // [SAMPLE_BITS-1:0] sample_out
	// register writes
	input  logic                                cfg_we,
	input  logic [tte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [tte_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	localparam int TDW      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int RING     = 4 * MAX_DELAY;
	localparam int FILL_CAP = 3 * MAX_DELAY;
	localparam int AW       = $clog2(RING);
	localparam int DW       = $clog2(FILL_CAP + 1);  // tap distance and fill count
	localparam int LW       = $clog2(MAX_DELAY + 1); // effective delay
	localparam int GB       = tte_pkg::GAIN_BITS;

	// sequencer: idle takes a beat and reads tap one, then one step per tap
	typedef enum logic [1:0] {
		ST_IDLE,    // accept, read tap one
		ST_TAP2,    // product one, read tap two
		ST_TAP3,    // product two, read tap three
		ST_WRITE    // product three, store the sample
	} state_t;

	state_t state_q;
	logic   fin_q;        // sum complete, waiting for the output register
	logic   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_data_q;
	logic [AW-1:0] wp_q;
	logic [DW-1:0] fill_q;

	// registers
	logic [tte_pkg::DELAY_BITS-1:0] delay_q;
	logic signed [GB-1:0] gain1_q;
	logic signed [GB-1:0] gain2_q;
	logic signed [GB-1:0] gain3_q;

	// per beat payload
	logic [LW-1:0] d_q;
	logic [SAMPLE_BITS-1:0] x_q;

	logic s_fire;
	logic fin_go;
	logic [LW-1:0] d_eff;
	logic [DW-1:0] dist2;
	logic [DW-1:0] dist3;
	logic [DW-1:0] dist_cur;
	logic signed [GB-1:0] gain_cur;

	logic ram_we;
	logic ram_re;
	logic [AW-1:0] ram_addr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	tte_pkg::tte_mac_ctl_t mac_ctl;
	logic signed [SAMPLE_BITS-1:0] mac_tap;
	logic signed [SAMPLE_BITS-1:0] mac_y;

	// slot span samples back from the write pointer, round the ring
	function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
			input logic [DW-1:0] span);
		logic [AW:0] t;
		t = {1'b0, wp} + (AW+1)'(RING) - (AW+1)'(span);
		if ({1'b0, wp} >= (AW+1)'(span)) begin
			t = {1'b0, wp} - (AW+1)'(span);
		end
		return t[AW-1:0];
	endfunction

	assign fin_go   = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && !(fin_q && !fin_go);
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDW'(out_data_q);

	// zero acts as one, anything past MAX_DELAY as MAX_DELAY
	always_comb begin
		if (delay_q == '0) begin
			d_eff = LW'(1);
		end else if (32'(delay_q) > 32'(MAX_DELAY)) begin
			d_eff = LW'(MAX_DELAY);
		end else begin
			d_eff = LW'(delay_q);
		end
	end

	assign dist2 = DW'(d_q) << 1;
	assign dist3 = dist2 + DW'(d_q);

	// memory port and tap selection per step
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = wp_q;
		dist_cur = DW'(d_q);
		gain_cur = gain1_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_re   = s_fire;
				ram_addr = tap_addr(wp_q, DW'(d_eff));
			end
			ST_TAP2: begin
				ram_re   = 1'b1;
				ram_addr = tap_addr(wp_q, dist2);
			end
			ST_TAP3: begin
				ram_re   = 1'b1;
				ram_addr = tap_addr(wp_q, dist3);
				dist_cur = dist2;
				gain_cur = gain2_q;
			end
			ST_WRITE: begin
				ram_we   = 1'b1;
				dist_cur = dist3;
				gain_cur = gain3_q;
			end
		endcase
	end

	// a tap not yet reached by the fill count adds nothing
	assign mac_tap = (fill_q >= dist_cur) ? $signed(ram_rdata) : '0;

	assign mac_ctl.load = s_fire;
	assign mac_ctl.mul  = (state_q != ST_IDLE);
	assign mac_ctl.add  = (state_q == ST_TAP3) || (state_q == ST_WRITE);

	tte_history_ram #(
		.DEPTH (RING),
		.WIDTH (SAMPLE_BITS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (x_q),
		.rdata (ram_rdata)
	);

	tte_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.gain   (gain_cur),
		.tap    (mac_tap),
		.result (mac_y)
	);

	// register writes; the user issues them only while nothing is in flight, the block itself does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= tte_pkg::DELAY_RST;
			gain1_q <= tte_pkg::GAIN1_RST;
			gain2_q <= tte_pkg::GAIN2_RST;
			gain3_q <= tte_pkg::GAIN3_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tte_pkg::REG_DELAY_LENGTH: delay_q <= cfg_data[tte_pkg::DELAY_BITS-1:0];
				tte_pkg::REG_FIRST_GAIN:   gain1_q <= $signed(cfg_data[GB-1:0]);
				tte_pkg::REG_SECOND_GAIN:  gain2_q <= $signed(cfg_data[GB-1:0]);
				tte_pkg::REG_THIRD_GAIN:   gain3_q <= $signed(cfg_data[GB-1:0]);
				default: ;
			endcase
		end
	end

	// beat payload held over the four steps
	always_ff @(posedge clk) begin
		if (s_fire) begin
			d_q <= d_eff;
			x_q <= s_tdata[SAMPLE_BITS-1:0];
		end
	end

	// sequencer, ring pointer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
		end else begin
			if (fin_q && fin_go) begin
				out_valid_q <= 1'b1;
				out_data_q  <= mac_y;
				fin_q       <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						state_q <= ST_TAP2;
					end
				end
				ST_TAP2: state_q <= ST_TAP3;
				ST_TAP3: state_q <= ST_WRITE;
				ST_WRITE: begin
					state_q <= ST_IDLE;
					fin_q   <= 1'b1;
					wp_q    <= (wp_q == AW'(RING - 1)) ? '0 : wp_q + 1'b1;
					if (fill_q < DW'(FILL_CAP)) begin
						fill_q <= fill_q + 1'b1;
					end
				end
			endcase
		end
	end

endmodule
